FILE: hw/rtl/urx_pkg.sv
// Shared types and constants for the 8N1 UART receiver with receive FIFO.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package urx_pkg;

  // Fixed field widths.
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LEVEL_W    = 6;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned FRAME_BITS = 10;
  localparam int unsigned BIT_IDX_W  = 4;

  // Index of the stop bit within a frame.
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd9;

  // Reset value of the bit period register.
  localparam logic [TICK_W-1:0] BIT_TICKS_RST = 16'd52;

  // Depth of the decoupling queue between the sampler and the FIFO side.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // One tick as it arrives on the input channel.
  typedef struct packed {
    logic rx_line;
    logic pop_req;
  } urx_in_t;

  // One result per tick on the output channel.
  typedef struct packed {
    logic [DATA_W-1:0]  pop_data;
    logic               pop_valid;
    logic               frame_done;
    logic               frame_error;
    logic               overflow;
    logic [LEVEL_W-1:0] fifo_level;
  } urx_out_t;

  // Classified tick handed from the sampler to the FIFO side.
  typedef struct packed {
    logic              pop_req;
    logic              frame_done;
    logic              frame_error;
    logic              push;
    logic [DATA_W-1:0] data;
  } urx_rec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/uart_rx_8n1_with_fifo.sv
// UART receiver, 8 data bits, no parity, one stop bit, with a receive FIFO.
// Top level; depends on urx_pkg, urx_front, urx_queue and urx_back.
//
// Usage:
//   Each request on the input channel is one sampling tick: the receive line
//   level and a pop request. Every accepted tick yields exactly one result
//   on the output channel with the popped byte, frame status flags and the
//   FIFO level after that tick. The bit period register is written through
//   cfg_we_i/cfg_wdata_i; the user must do so only while no ticks are in
//   flight, as the block itself does not enforce it.
// Throughput and registers:
//   One tick per clock cycle while in_stall_o is low. Each tick is registered
//   in the two-entry queue behind the line sampler, then in the output
//   register behind the FIFO memory, whose read port is used once per tick.
// Reset:
//   The sampler is idle, the FIFO is empty and the bit period is 52 ticks.
// Stalls:
//   When out_stall_i is high the result is held; ticks keep entering until
//   the queue is full, then in_stall_o rises until the output moves again.
`default_nettype none

module uart_rx_8n1_with_fifo #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [urx_pkg::TICK_W-1:0]  cfg_wdata_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  urx_pkg::urx_in_t      in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output urx_pkg::urx_out_t           out_data_o
);

  logic [urx_pkg::TICK_W-1:0] bit_ticks_q;
  logic                       in_accept;
  logic                       q_valid, q_stall;
  urx_pkg::urx_rec_t          front_rec, q_rec;

  // Bit period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= urx_pkg::BIT_TICKS_RST;
    end else if (cfg_we_i) begin
      bit_ticks_q <= cfg_wdata_i;
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Line sampler.
  urx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_ticks_i (bit_ticks_q),
    .in_i        (in_data_i),
    .accept_i    (in_accept),
    .rec_o       (front_rec)
  );

  // Decoupling queue.
  urx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_rec_i   (front_rec),
    .pop_valid_o  (q_valid),
    .pop_stall_i  (q_stall),
    .pop_rec_o    (q_rec)
  );

  // Receive FIFO and output register.
  urx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_stall_o (q_stall),
    .rec_i       (q_rec),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/urx_front.sv
// Line sampler: tracks the frame timing and classifies each tick.
// Depends on urx_pkg.
`default_nettype none

module urx_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  [urx_pkg::TICK_W-1:0]  bit_ticks_i,
  input  wire  urx_pkg::urx_in_t      in_i,
  input  wire                         accept_i,
  output urx_pkg::urx_rec_t           rec_o
);

  logic                            receiving_q, receiving_d;
  logic [urx_pkg::TICK_W-1:0]      tick_q, tick_d;
  logic [urx_pkg::BIT_IDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [urx_pkg::FRAME_BITS-1:0]  shift_q, shift_d;
  logic [urx_pkg::TICK_W-1:0]      tick_inc;
  logic                            sample;
  logic [urx_pkg::FRAME_BITS-1:0]  shift_new;
  logic                            last;

  // Bit timing and sample decision.
  always_comb begin
    tick_inc  = tick_q + 16'd1;
    sample    = receiving_q && (tick_inc >= bit_ticks_i);
    shift_new = shift_q | ({{(urx_pkg::FRAME_BITS-1){1'b0}}, in_i.rx_line} << bit_idx_q);
    last      = sample && (bit_idx_q >= urx_pkg::LAST_BIT);
  end

  // Next state of the frame tracker.
  always_comb begin
    receiving_d = receiving_q;
    tick_d      = tick_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    if (!receiving_q) begin
      if (!in_i.rx_line) begin
        receiving_d = 1'b1;
        bit_idx_d   = '0;
        shift_d     = '0;
        tick_d      = bit_ticks_i >> 1;
      end
    end else if (sample) begin
      tick_d  = '0;
      shift_d = shift_new;
      if (last) begin
        receiving_d = 1'b0;
        bit_idx_d   = '0;
      end else begin
        bit_idx_d = bit_idx_q + 4'd1;
      end
    end else begin
      tick_d = tick_inc;
    end
  end

  // Classification of this tick for the FIFO side.
  always_comb begin
    rec_o.pop_req     = in_i.pop_req;
    rec_o.frame_done  = last;
    rec_o.frame_error = last && (shift_new[0] || !shift_new[urx_pkg::FRAME_BITS-1]);
    rec_o.data        = shift_new[urx_pkg::DATA_W:1];
    rec_o.push        = last && !shift_new[0] && shift_new[urx_pkg::FRAME_BITS-1]
                        && (shift_new[urx_pkg::DATA_W:1] != '0);
  end

  // State registers advance only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      tick_q      <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
    end else if (accept_i) begin
      receiving_q <= receiving_d;
      tick_q      <= tick_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/urx_queue.sv
// Two-entry queue of classified ticks between the sampler and the FIFO side.
// Depends on urx_pkg.
`default_nettype none

module urx_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_valid_i,
  output logic                  push_stall_o,
  input  wire  urx_pkg::urx_rec_t push_rec_i,
  output logic                  pop_valid_o,
  input  wire                   pop_stall_i,
  output urx_pkg::urx_rec_t     pop_rec_o
);

  urx_pkg::urx_rec_t              entry_q [urx_pkg::QUEUE_DEPTH];
  logic [urx_pkg::QUEUE_AW-1:0]   wr_q, rd_q;
  logic [urx_pkg::QUEUE_AW:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  // Handshake on both sides.
  always_comb begin
    push_stall_o = (cnt_q == (urx_pkg::QUEUE_AW+1)'(urx_pkg::QUEUE_DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_rec_o    = entry_q[rd_q];
    do_push      = push_valid_i && !push_stall_o;
    do_pop       = pop_valid_o && !pop_stall_i;
    cnt_d        = cnt_q + {{urx_pkg::QUEUE_AW{1'b0}}, do_push}
                         - {{urx_pkg::QUEUE_AW{1'b0}}, do_pop};
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_rec_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/urx_back.sv
// Receive FIFO and output register: applies pops and pushes in tick order.
// Depends on urx_pkg.
`default_nettype none

module urx_back #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     rec_valid_i,
  output logic                    rec_stall_o,
  input  wire  urx_pkg::urx_rec_t rec_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output urx_pkg::urx_out_t       out_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [urx_pkg::DATA_W-1:0] mem_q [FIFO_DEPTH];
  logic [urx_pkg::DATA_W-1:0] rdata_q;
  logic [PW-1:0]              rd_ptr_q, wr_ptr_q;
  logic [CW-1:0]              cnt_q, cnt_d, cnt_pop;
  logic                       out_valid_q;
  logic                       pop_valid_q, done_q, ferr_q, ovf_q;
  logic                       adv, pop_ok, push_ok, ovf;
  logic [CW+urx_pkg::LEVEL_W-1:0] level_ext;

  // Pop is applied before push, so a full FIFO that is popped takes the byte.
  always_comb begin
    rec_stall_o = out_valid_q && out_stall_i;
    adv         = rec_valid_i && !rec_stall_o;
    pop_ok      = rec_i.pop_req && (cnt_q != '0);
    cnt_pop     = cnt_q - {{(CW-1){1'b0}}, pop_ok};
    ovf         = rec_i.push && (cnt_pop == CW'(FIFO_DEPTH));
    push_ok     = rec_i.push && !ovf;
    cnt_d       = cnt_pop + {{(CW-1){1'b0}}, push_ok};
  end

  // FIFO pointers, count and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pop_valid_q <= 1'b0;
      done_q      <= 1'b0;
      ferr_q      <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      if (adv) begin
        if (pop_ok) begin
          rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
        end
        if (push_ok) begin
          wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
        end
        cnt_q       <= cnt_d;
        pop_valid_q <= pop_ok;
        done_q      <= rec_i.frame_done;
        ferr_q      <= rec_i.frame_error;
        ovf_q       <= ovf;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Byte storage with registered read at the read pointer.
  always_ff @(posedge clk_i) begin
    if (adv && push_ok) begin
      mem_q[wr_ptr_q] <= rec_i.data;
    end
    if (adv) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  // Result assembly; the level reports the low bits of the count.
  always_comb begin
    level_ext        = {{urx_pkg::LEVEL_W{1'b0}}, cnt_q};
    out_valid_o      = out_valid_q;
    out_o.pop_data   = pop_valid_q ? rdata_q : '0;
    out_o.pop_valid  = pop_valid_q;
    out_o.frame_done = done_q;
    out_o.frame_error = ferr_q;
    out_o.overflow   = ovf_q;
    out_o.fifo_level = level_ext[urx_pkg::LEVEL_W-1:0];
  end

  // The count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(FIFO_DEPTH))
    else $error("FIFO count above depth");

  // An empty FIFO has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty FIFO with pointers apart");

  // Overflow only on a good finished frame with the FIFO full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |-> (done_q && !ferr_q && cnt_q == CW'(FIFO_DEPTH)))
    else $error("overflow without a full FIFO and a good frame");

  // A pop that returns a byte leaves room in the FIFO.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && pop_ok && !push_ok) |=> (cnt_q != CW'(FIFO_DEPTH)))
    else $error("pop did not free an entry");

endmodule

`default_nettype wire
